[design/pmw_pkg.sv]
// Shared types, constants and microcode word layout for the particle motion unit.
package pmw_pkg;

    localparam int VALUE_BITS_DEF    = 24;
    localparam int FRACTION_BITS_DEF = 8;

    localparam int FIELD_W = 24;
    localparam int GRAV_W  = 24;
    localparam int CFG_W   = 16;
    localparam int DT_W    = 16;
    localparam int APB_DW  = 32;
    localparam int PADDR_W = 5;
    localparam int PC_W    = 4;

    localparam logic [CFG_W-1:0] DAMP_RESET   = 16'd32768;
    localparam logic [CFG_W-1:0] WIDTH_RESET  = 16'd1024;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 16'd768;
    localparam logic [CFG_W-1:0] RADIUS_RESET = 16'd1280;

    typedef enum logic [2:0] {
        REG_GRAVITY_X       = 3'd0,
        REG_GRAVITY_Y       = 3'd1,
        REG_DAMPING_X       = 3'd2,
        REG_DAMPING_Y       = 3'd3,
        REG_AREA_WIDTH      = 3'd4,
        REG_AREA_HEIGHT     = 3'd5,
        REG_PARTICLE_RADIUS = 3'd6
    } reg_idx_t;

    typedef enum logic [2:0] {
        MA_DT,
        MA_VX,
        MA_VY,
        MA_GX,
        MA_GY,
        MA_NVX,
        MA_NVY
    } mul_a_t;

    typedef enum logic [1:0] {
        MB_DT,
        MB_DT2,
        MB_DX,
        MB_DY
    } mul_b_t;

    typedef enum logic [2:0] {
        WB_NONE,
        WB_DT2,
        WB_PX_ADD,
        WB_PY_ADD,
        WB_VX_ADD,
        WB_VY_ADD,
        WB_VX_BOUNCE,
        WB_VY_BOUNCE
    } wb_t;

    typedef enum logic [1:0] {
        SH_15,
        SH_16,
        SH_17
    } shift_t;

    typedef enum logic [1:0] {
        SQ_NEXT,
        SQ_SKIP_NOHIT,
        SQ_FINISH
    } seq_t;

    typedef struct packed {
        mul_a_t          mul_a;
        mul_b_t          mul_b;
        wb_t             wb;
        shift_t          shift;
        logic            wall_test;
        logic            wall_clamp;
        seq_t            seq;
        logic [PC_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        ucode_t uc;
        logic   finish;
    } dp_ctrl_t;

    typedef struct packed {
        logic [GRAV_W-1:0] gravity_x;
        logic [GRAV_W-1:0] gravity_y;
        logic [CFG_W-1:0]  damping_x;
        logic [CFG_W-1:0]  damping_y;
        logic [CFG_W-1:0]  area_width;
        logic [CFG_W-1:0]  area_height;
        logic [CFG_W-1:0]  particle_radius;
    } cfg_t;

    localparam logic [PC_W-1:0] UA_ADVANCE = 4'd0;
    localparam logic [PC_W-1:0] UA_FINISH  = 4'd12;

    localparam ucode_t UC_NOP = '{
        mul_a:      MA_DT,
        mul_b:      MB_DT,
        wb:         WB_NONE,
        shift:      SH_16,
        wall_test:  1'b0,
        wall_clamp: 1'b0,
        seq:        SQ_NEXT,
        target:     UA_ADVANCE
    };

endpackage

[design/pmw_apb_regs.sv]
// Configuration register bank behind the APB port.
module pmw_apb_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pmw_pkg::PADDR_W-1:0]   paddr,
    input  logic [pmw_pkg::APB_DW-1:0]    pwdata,
    output logic [pmw_pkg::APB_DW-1:0]    prdata,
    output pmw_pkg::cfg_t                 cfg
);
    import pmw_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx   = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_GRAVITY_X:       cfg_next.gravity_x       = pwdata[GRAV_W-1:0];
                REG_GRAVITY_Y:       cfg_next.gravity_y       = pwdata[GRAV_W-1:0];
                REG_DAMPING_X:       cfg_next.damping_x       = pwdata[CFG_W-1:0];
                REG_DAMPING_Y:       cfg_next.damping_y       = pwdata[CFG_W-1:0];
                REG_AREA_WIDTH:      cfg_next.area_width      = pwdata[CFG_W-1:0];
                REG_AREA_HEIGHT:     cfg_next.area_height     = pwdata[CFG_W-1:0];
                REG_PARTICLE_RADIUS: cfg_next.particle_radius = pwdata[CFG_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_GRAVITY_X:       prdata = APB_DW'(cfg_reg.gravity_x);
            REG_GRAVITY_Y:       prdata = APB_DW'(cfg_reg.gravity_y);
            REG_DAMPING_X:       prdata = APB_DW'(cfg_reg.damping_x);
            REG_DAMPING_Y:       prdata = APB_DW'(cfg_reg.damping_y);
            REG_AREA_WIDTH:      prdata = APB_DW'(cfg_reg.area_width);
            REG_AREA_HEIGHT:     prdata = APB_DW'(cfg_reg.area_height);
            REG_PARTICLE_RADIUS: prdata = APB_DW'(cfg_reg.particle_radius);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gravity_x       <= '0;
            cfg_reg.gravity_y       <= '0;
            cfg_reg.damping_x       <= DAMP_RESET;
            cfg_reg.damping_y       <= DAMP_RESET;
            cfg_reg.area_width      <= WIDTH_RESET;
            cfg_reg.area_height     <= HEIGHT_RESET;
            cfg_reg.particle_radius <= RADIUS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[design/pmw_ucode_rom.sv]
// Microcode store: one control word per sequencer step.
module pmw_ucode_rom (
    input  logic [pmw_pkg::PC_W-1:0] addr,
    output pmw_pkg::ucode_t          word
);
    import pmw_pkg::*;

    function automatic ucode_t uw(
        input mul_a_t          a,
        input mul_b_t          b,
        input wb_t             w,
        input shift_t          s,
        input logic            test,
        input logic            clamp,
        input seq_t            q,
        input logic [PC_W-1:0] tgt
    );
        ucode_t u;
        u.mul_a      = a;
        u.mul_b      = b;
        u.wb         = w;
        u.shift      = s;
        u.wall_test  = test;
        u.wall_clamp = clamp;
        u.seq        = q;
        u.target     = tgt;
        return u;
    endfunction

    always_comb
    begin
        unique case (addr)
            4'd0:  word = uw(MA_DT,  MB_DT,  WB_NONE,      SH_16, 1'b0, 1'b0, SQ_NEXT, UA_ADVANCE);
            4'd1:  word = uw(MA_VX,  MB_DT,  WB_DT2,       SH_16, 1'b0, 1'b0, SQ_NEXT, UA_ADVANCE);
            4'd2:  word = uw(MA_VY,  MB_DT,  WB_PX_ADD,    SH_16, 1'b0, 1'b0, SQ_NEXT, UA_ADVANCE);
            4'd3:  word = uw(MA_GX,  MB_DT2, WB_PY_ADD,    SH_16, 1'b0, 1'b0, SQ_NEXT, UA_ADVANCE);
            4'd4:  word = uw(MA_GY,  MB_DT2, WB_PX_ADD,    SH_17, 1'b0, 1'b0, SQ_NEXT, UA_ADVANCE);
            4'd5:  word = uw(MA_GX,  MB_DT,  WB_PY_ADD,    SH_17, 1'b0, 1'b0, SQ_NEXT, UA_ADVANCE);
            4'd6:  word = uw(MA_GY,  MB_DT,  WB_VX_ADD,    SH_16, 1'b0, 1'b0, SQ_NEXT, UA_ADVANCE);
            4'd7:  word = uw(MA_DT,  MB_DT,  WB_VY_ADD,    SH_16, 1'b0, 1'b0, SQ_NEXT, UA_ADVANCE);
            4'd8:  word = uw(MA_DT,  MB_DT,  WB_NONE,      SH_16, 1'b1, 1'b0,
                             SQ_SKIP_NOHIT, UA_FINISH);
            4'd9:  word = uw(MA_NVX, MB_DX,  WB_NONE,      SH_15, 1'b0, 1'b1, SQ_NEXT, UA_ADVANCE);
            4'd10: word = uw(MA_NVY, MB_DY,  WB_VX_BOUNCE, SH_15, 1'b0, 1'b0, SQ_NEXT, UA_ADVANCE);
            4'd11: word = uw(MA_DT,  MB_DT,  WB_VY_BOUNCE, SH_15, 1'b0, 1'b0, SQ_NEXT, UA_ADVANCE);
            4'd12: word = uw(MA_DT,  MB_DT,  WB_NONE,      SH_16, 1'b0, 1'b0, SQ_FINISH, UA_ADVANCE);
            default: word = UC_NOP;
        endcase
    end

endmodule

[design/pmw_sequencer.sv]
// Step counter with conditional jumps that walks the microcode program.
module pmw_sequencer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               operation,
    input  logic               hit_any,
    input  logic               out_free,
    output logic               busy,
    output pmw_pkg::dp_ctrl_t  ctrl
);
    import pmw_pkg::*;

    logic            busy_reg;
    logic            busy_next;
    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    ucode_t          uc;

    pmw_ucode_rom u_rom (
        .addr (pc_reg),
        .word (uc)
    );

    assign busy        = busy_reg;
    assign ctrl.uc     = busy_reg ? uc : UC_NOP;
    assign ctrl.finish = busy_reg && (uc.seq == SQ_FINISH) && out_free;

    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                pc_next   = operation ? UA_FINISH : UA_ADVANCE;
            end
        end
        else
        begin
            unique case (uc.seq)
                SQ_NEXT:       pc_next = pc_reg + PC_W'(1);
                SQ_SKIP_NOHIT: pc_next = hit_any ? pc_reg + PC_W'(1) : uc.target;
                SQ_FINISH:
                begin
                    if (out_free)
                        busy_next = 1'b0;
                end
                default:       busy_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= UA_ADVANCE;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

endmodule

[design/pmw_datapath.sv]
// Shared multiplier, rounding adder, wall logic, particle state and output register.
module pmw_datapath #(
    parameter int VALUE_BITS    = pmw_pkg::VALUE_BITS_DEF,
    parameter int FRACTION_BITS = pmw_pkg::FRACTION_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pmw_pkg::cfg_t                        cfg,
    input  pmw_pkg::dp_ctrl_t                    ctrl,
    input  logic                                 accept,
    input  logic                                 operation,
    input  logic [pmw_pkg::DT_W-1:0]             step_time,
    input  logic signed [pmw_pkg::FIELD_W-1:0]   load_pos_x,
    input  logic signed [pmw_pkg::FIELD_W-1:0]   load_pos_y,
    input  logic signed [pmw_pkg::FIELD_W-1:0]   load_vel_x,
    input  logic signed [pmw_pkg::FIELD_W-1:0]   load_vel_y,
    input  logic                                 out_stall,
    output logic                                 hit_any,
    output logic                                 out_free,
    output logic                                 out_valid,
    output logic signed [pmw_pkg::FIELD_W-1:0]   pos_x,
    output logic signed [pmw_pkg::FIELD_W-1:0]   pos_y,
    output logic signed [pmw_pkg::FIELD_W-1:0]   vel_x,
    output logic signed [pmw_pkg::FIELD_W-1:0]   vel_y,
    output logic                                 bounced_x,
    output logic                                 bounced_y,
    output logic                                 saturated
);
    import pmw_pkg::*;

    localparam int DW = ((VALUE_BITS > 28) ? VALUE_BITS : 28) + 4;
    localparam int BW = DT_W + 1;
    localparam int PW = DW + BW;
    localparam int TW = DW + 2;
    localparam int TENTH_I = (1 << FRACTION_BITS) / 10;

    localparam logic signed [DW-1:0] SAT_HI =
        {{(DW-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [DW-1:0] SAT_LO =
        {{(DW-VALUE_BITS+1){1'b1}}, {(VALUE_BITS-1){1'b0}}};
    localparam logic signed [TW-1:0] TENTH = TW'(TENTH_I);
    localparam logic signed [PW:0] HALF15 = {{(PW-14){1'b0}}, 1'b1, 14'b0};
    localparam logic signed [PW:0] HALF16 = {{(PW-15){1'b0}}, 1'b1, 15'b0};
    localparam logic signed [PW:0] HALF17 = {{(PW-16){1'b0}}, 1'b1, 16'b0};

    function automatic logic signed [DW-1:0] clip(input logic signed [DW-1:0] x);
        logic signed [DW-1:0] y;
        if (x > SAT_HI)
            y = SAT_HI;
        else if (x < SAT_LO)
            y = SAT_LO;
        else
            y = x;
        return y;
    endfunction

    logic signed [DW-1:0] px_reg, py_reg, vx_reg, vy_reg;
    logic signed [DW-1:0] px_next, py_next, vx_next, vy_next;
    logic [DT_W-1:0]      dt_reg;
    logic [DT_W-1:0]      dt2_reg, dt2_next;
    logic signed [PW-1:0] prod_reg;
    logic                 bx_reg, by_reg, bx_next, by_next;

    logic signed [DW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic signed [PW-1:0] prod_next;
    logic signed [PW:0]   prod_ext;
    logic signed [PW:0]   rsum;
    logic signed [DW-1:0] rnd_val;

    logic [TW-1:0]        r_raw;
    logic signed [TW-1:0] r_t, w_t, h_t, px_t, py_t;
    logic signed [TW-1:0] hi_x, hi_y, cx, cy;
    logic                 hit_x, hit_y;

    logic signed [DW-1:0] px_sat, py_sat, vx_sat, vy_sat;
    logic                 sat_any;

    logic                       out_valid_reg;
    logic [FIELD_W-1:0]         pos_x_reg, pos_y_reg, vel_x_reg, vel_y_reg;
    logic                       bounced_x_reg, bounced_y_reg, saturated_reg;

    // shared multiplier operands
    always_comb
    begin
        unique case (ctrl.uc.mul_a)
            MA_DT:   mul_a = $signed({{(DW-DT_W){1'b0}}, dt_reg});
            MA_VX:   mul_a = vx_reg;
            MA_VY:   mul_a = vy_reg;
            MA_GX:   mul_a = $signed({{(DW-GRAV_W){cfg.gravity_x[GRAV_W-1]}}, cfg.gravity_x});
            MA_GY:   mul_a = $signed({{(DW-GRAV_W){cfg.gravity_y[GRAV_W-1]}}, cfg.gravity_y});
            MA_NVX:  mul_a = -vx_reg;
            MA_NVY:  mul_a = -vy_reg;
            default: mul_a = '0;
        endcase
        unique case (ctrl.uc.mul_b)
            MB_DT:   mul_b = $signed({1'b0, dt_reg});
            MB_DT2:  mul_b = $signed({1'b0, dt2_reg});
            MB_DX:   mul_b = $signed({1'b0, cfg.damping_x});
            MB_DY:   mul_b = $signed({1'b0, cfg.damping_y});
            default: mul_b = '0;
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // round half up on the registered product
    always_comb
    begin
        prod_ext = {prod_reg[PW-1], prod_reg};
        unique case (ctrl.uc.shift)
            SH_15:
            begin
                rsum    = prod_ext + HALF15;
                rnd_val = rsum[DW+14:15];
            end
            SH_16:
            begin
                rsum    = prod_ext + HALF16;
                rnd_val = rsum[DW+15:16];
            end
            SH_17:
            begin
                rsum    = prod_ext + HALF17;
                rnd_val = rsum[DW+16:17];
            end
            default:
            begin
                rsum    = prod_ext + HALF16;
                rnd_val = rsum[DW+15:16];
            end
        endcase
    end

    generate
        if (FRACTION_BITS >= 8)
        begin : g_rad_up
            assign r_raw = TW'(cfg.particle_radius) << (FRACTION_BITS - 8);
        end
        else
        begin : g_rad_down
            localparam logic [TW-1:0] RAD_HALF = TW'(1) << (7 - FRACTION_BITS);
            assign r_raw = (TW'(cfg.particle_radius) + RAD_HALF) >> (8 - FRACTION_BITS);
        end
    endgenerate

    assign r_t  = r_raw;
    assign w_t  = TW'(cfg.area_width) << FRACTION_BITS;
    assign h_t  = TW'(cfg.area_height) << FRACTION_BITS;
    assign px_t = {{2{px_reg[DW-1]}}, px_reg};
    assign py_t = {{2{py_reg[DW-1]}}, py_reg};

    assign hit_y   = ((py_t <<< 1) + r_t >= (h_t <<< 1)) || (py_t - r_t <= TENTH);
    assign hit_x   = (px_t + r_t >= w_t) || (px_t - r_t <= TENTH);
    assign hit_any = hit_x || hit_y;

    always_comb
    begin
        hi_x = w_t - r_t;
        hi_y = h_t - r_t;
        cx   = px_t;
        cy   = py_t;
        if (cx > hi_x)
            cx = hi_x;
        if (cx < r_t)
            cx = r_t;
        if (cy > hi_y)
            cy = hi_y;
        if (cy < r_t)
            cy = r_t;
    end

    assign px_sat  = clip(px_reg);
    assign py_sat  = clip(py_reg);
    assign vx_sat  = clip(vx_reg);
    assign vy_sat  = clip(vy_reg);
    assign sat_any = (px_sat != px_reg) || (py_sat != py_reg) ||
                     (vx_sat != vx_reg) || (vy_sat != vy_reg);

    always_comb
    begin
        px_next  = px_reg;
        py_next  = py_reg;
        vx_next  = vx_reg;
        vy_next  = vy_reg;
        dt2_next = dt2_reg;
        bx_next  = bx_reg;
        by_next  = by_reg;

        case (ctrl.uc.wb)
            WB_NONE:      ;
            WB_DT2:       dt2_next = rnd_val[DT_W-1:0];
            WB_PX_ADD:    px_next  = px_reg + rnd_val;
            WB_PY_ADD:    py_next  = py_reg + rnd_val;
            WB_VX_ADD:    vx_next  = vx_reg + rnd_val;
            WB_VY_ADD:    vy_next  = vy_reg + rnd_val;
            WB_VX_BOUNCE:
            begin
                if (bx_reg)
                    vx_next = rnd_val;
            end
            WB_VY_BOUNCE:
            begin
                if (by_reg)
                    vy_next = rnd_val;
            end
            default:      ;
        endcase

        if (ctrl.uc.wall_test)
        begin
            bx_next = hit_x;
            by_next = hit_y;
        end

        if (ctrl.uc.wall_clamp)
        begin
            if (bx_reg)
                px_next = cx[DW-1:0];
            if (by_reg)
                py_next = cy[DW-1:0];
        end

        if (ctrl.finish)
        begin
            px_next = px_sat;
            py_next = py_sat;
            vx_next = vx_sat;
            vy_next = vy_sat;
        end

        if (accept)
        begin
            bx_next = 1'b0;
            by_next = 1'b0;
            if (operation)
            begin
                px_next = {{(DW-FIELD_W){load_pos_x[FIELD_W-1]}}, load_pos_x};
                py_next = {{(DW-FIELD_W){load_pos_y[FIELD_W-1]}}, load_pos_y};
                vx_next = {{(DW-FIELD_W){load_vel_x[FIELD_W-1]}}, load_vel_x};
                vy_next = {{(DW-FIELD_W){load_vel_y[FIELD_W-1]}}, load_vel_y};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            px_reg        <= '0;
            py_reg        <= '0;
            vx_reg        <= '0;
            vy_reg        <= '0;
            bx_reg        <= 1'b0;
            by_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            px_reg <= px_next;
            py_reg <= py_next;
            vx_reg <= vx_next;
            vy_reg <= vy_next;
            bx_reg <= bx_next;
            by_reg <= by_next;
            if (ctrl.finish)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        dt2_reg  <= dt2_next;
        if (accept)
            dt_reg <= step_time;
        if (ctrl.finish)
        begin
            pos_x_reg     <= px_sat[FIELD_W-1:0];
            pos_y_reg     <= py_sat[FIELD_W-1:0];
            vel_x_reg     <= vx_sat[FIELD_W-1:0];
            vel_y_reg     <= vy_sat[FIELD_W-1:0];
            bounced_x_reg <= bx_reg;
            bounced_y_reg <= by_reg;
            saturated_reg <= sat_any;
        end
    end

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign vel_x     = vel_x_reg;
    assign vel_y     = vel_y_reg;
    assign bounced_x = bounced_x_reg;
    assign bounced_y = bounced_y_reg;
    assign saturated = saturated_reg;

endmodule

[design/particle_motion_with_walls_unit.sv]
// Top level of the particle motion unit with wall bounce.
//
//   port group   direction  handshake             payload
//   input item   in         in_valid / in_stall   operation, step_time, load_*
//   result item  out        out_valid / out_stall pos_*, vel_*, bounced_*, saturated
//   config       in/out     APB psel / penable    paddr, pwdata, prdata
//
// An advance walks the microcode over the one shared multiplier, skipping the
// bounce steps when no wall is hit; a load goes straight to the finish step.
// One item is in work at a time; in_stall stays high until its result is
// registered. A stalled result holds the final step until the output frees.
// Reset clears the particle state to zero and the registers to their defaults.
module particle_motion_with_walls_unit #(
    parameter int VALUE_BITS    = pmw_pkg::VALUE_BITS_DEF,
    parameter int FRACTION_BITS = pmw_pkg::FRACTION_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pmw_pkg::PADDR_W-1:0]          paddr,
    input  logic [pmw_pkg::APB_DW-1:0]           pwdata,
    output logic [pmw_pkg::APB_DW-1:0]           prdata,
    output logic                                 pready,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 operation,
    input  logic [pmw_pkg::DT_W-1:0]             step_time,
    input  logic signed [pmw_pkg::FIELD_W-1:0]   load_pos_x,
    input  logic signed [pmw_pkg::FIELD_W-1:0]   load_pos_y,
    input  logic signed [pmw_pkg::FIELD_W-1:0]   load_vel_x,
    input  logic signed [pmw_pkg::FIELD_W-1:0]   load_vel_y,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [pmw_pkg::FIELD_W-1:0]   pos_x,
    output logic signed [pmw_pkg::FIELD_W-1:0]   pos_y,
    output logic signed [pmw_pkg::FIELD_W-1:0]   vel_x,
    output logic signed [pmw_pkg::FIELD_W-1:0]   vel_y,
    output logic                                 bounced_x,
    output logic                                 bounced_y,
    output logic                                 saturated
);
    import pmw_pkg::*;

    cfg_t     cfg;
    dp_ctrl_t ctrl;
    logic     busy;
    logic     accept;
    logic     hit_any;
    logic     out_free;

    assign pready   = 1'b1;
    assign in_stall = busy;
    assign accept   = in_valid && !busy;

    pmw_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    pmw_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .operation (operation),
        .hit_any   (hit_any),
        .out_free  (out_free),
        .busy      (busy),
        .ctrl      (ctrl)
    );

    pmw_datapath #(
        .VALUE_BITS    (VALUE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .ctrl       (ctrl),
        .accept     (accept),
        .operation  (operation),
        .step_time  (step_time),
        .load_pos_x (load_pos_x),
        .load_pos_y (load_pos_y),
        .load_vel_x (load_vel_x),
        .load_vel_y (load_vel_y),
        .out_stall  (out_stall),
        .hit_any    (hit_any),
        .out_free   (out_free),
        .out_valid  (out_valid),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .vel_x      (vel_x),
        .vel_y      (vel_y),
        .bounced_x  (bounced_x),
        .bounced_y  (bounced_y),
        .saturated  (saturated)
    );

endmodule
